/* rtl/vri_pkg.sv */
// Shared types, constants and address mapping for the video register interface.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package vri_pkg;

    localparam int NAMETABLE_BYTES  = 2048;
    localparam int SPRITE_MEM_BYTES = 256;
    localparam int PALETTE_ENTRIES  = 32;

    // unified storage: name tables, then sprite attributes, then palette
    localparam int MEM_DEPTH = NAMETABLE_BYTES + SPRITE_MEM_BYTES + PALETTE_ENTRIES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [MEM_AW-1:0] OAM_BASE = MEM_AW'(NAMETABLE_BYTES);
    localparam logic [MEM_AW-1:0] PAL_BASE = MEM_AW'(NAMETABLE_BYTES + SPRITE_MEM_BYTES);
    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_DEPTH - 1);

    localparam logic [5:0] PAL_WINDOW = 6'h3F;  // bus bits 13:8 of the palette page

    typedef enum logic [1:0] {
        REQ_READ,
        REQ_WRITE,
        REQ_VBLANK,
        REQ_PRE_CLEAR
    } req_type_t;

    typedef enum logic [2:0] {
        SEL_CTRL,
        SEL_MASK,
        SEL_STATUS,
        SEL_OAM_ADDR,
        SEL_OAM_DATA,
        SEL_SCROLL,
        SEL_ADDR,
        SEL_DATA
    } reg_sel_t;

    typedef enum logic [1:0] {
        MIR_VERTICAL,
        MIR_HORIZONTAL,
        MIR_LOWER,
        MIR_UPPER
    } mirror_t;

    typedef struct packed {
        req_type_t  req_type;
        reg_sel_t   reg_select;
        logic [7:0] write_data;
        logic [7:0] pattern_read_data;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_request;
        logic        pattern_read;
        logic        pattern_write;
        logic [12:0] pattern_address;
        logic [7:0]  pattern_write_data;
        logic [14:0] current_vram_address;
    } result_t;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // Bus address (14 bits) to storage address for name table and palette space.
    function automatic logic [MEM_AW-1:0] vram_to_mem(input logic [13:0] a, input mirror_t mode);
        logic [4:0]  p;
        logic [10:0] nt;
        p = a[4:0];
        if (p[1:0] == 2'b00)
        begin
            p[4] = 1'b0;   // backdrop entries alias the background set
        end
        unique case (mode)
            MIR_VERTICAL:   nt = a[10:0];
            MIR_HORIZONTAL: nt = {a[11], a[9:0]};
            MIR_LOWER:      nt = {1'b0, a[9:0]};
            MIR_UPPER:      nt = {1'b1, a[9:0]};
            default:        nt = a[10:0];
        endcase
        if (a[13:8] == PAL_WINDOW)
        begin
            return PAL_BASE | MEM_AW'(p);
        end
        return MEM_AW'(nt);
    endfunction

    // Power-up contents: palette entry i holds i, everything else zero.
    function automatic logic [7:0] init_value(input logic [MEM_AW-1:0] addr);
        if (addr >= PAL_BASE)
        begin
            return 8'(addr - PAL_BASE);
        end
        return 8'd0;
    endfunction

endpackage

/* rtl/vri_mem.sv */
// Single-port storage for name tables, sprite attributes and palette, with
// the power-up fill sweep. Depends on vri_pkg.
`timescale 1ns / 1ps

module vri_mem
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  vri_pkg::mem_req_t        req,
    output logic [7:0]               rdata,
    output logic                     busy
);

    logic [7:0]                  mem [0:vri_pkg::MEM_DEPTH-1];
    logic [7:0]                  rdata_reg;
    logic [vri_pkg::MEM_AW-1:0]  clr_addr_reg;
    logic [vri_pkg::MEM_AW-1:0]  clr_addr_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        wr_en;
    logic [vri_pkg::MEM_AW-1:0]  wr_addr;
    logic [7:0]                  wr_data;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + vri_pkg::MEM_AW'(1);
            if (clr_addr_reg == vri_pkg::CLR_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = vri_pkg::init_value(clr_addr_reg);
        end
        else
        begin
            wr_en   = req.we;
            wr_addr = req.addr;
            wr_data = req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

`ifndef ASSERT_OFF
    a_no_access_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (!req.re && !req.we))
        else $error("item access during fill sweep");

    a_fill_ends_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(clr_addr_reg) == vri_pkg::CLR_LAST))
        else $error("fill sweep ended early");
`endif

endmodule

/* rtl/vri_regs.sv */
// Register file and item sequencer: read storage on accept, update and write
// back when the item commits, hold the result for the consumer. Depends on vri_pkg.
`timescale 1ns / 1ps

module vri_regs
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  vri_pkg::mirror_t     mirroring,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vri_pkg::item_t       s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vri_pkg::result_t     m_result,
    output vri_pkg::mem_req_t    mem_req,
    input  logic [7:0]           mem_rdata,
    input  logic                 mem_busy
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                      state_reg, state_next;
    vri_pkg::item_t              item_reg, item_next;
    logic [vri_pkg::MEM_AW-1:0]  maddr_reg, maddr_next;
    logic                        m_valid_reg, m_valid_next;
    vri_pkg::result_t            result_reg, result_next;
    logic [7:0]                  ctrl_reg, ctrl_next;
    logic [7:0]                  mask_reg, mask_next;      // held for the renderer
    logic [7:0]                  status_reg, status_next;
    logic [14:0]                 t_reg, t_next;
    logic [14:0]                 v_reg, v_next;
    logic [2:0]                  fine_x_reg, fine_x_next;  // held for the renderer
    logic                        toggle_reg, toggle_next;
    logic [7:0]                  rbuf_reg, rbuf_next;
    logic [7:0]                  ptr_reg, ptr_next;

    logic                        accept;
    logic                        commit;
    logic                        in_pat;
    logic                        in_pal;
    logic [7:0]                  fetched;
    logic [14:0]                 v_inc;
    logic [vri_pkg::MEM_AW-1:0]  acc_addr;
    vri_pkg::result_t            res;

    assign s_ready = (state_reg == ST_IDLE) && !mem_busy;
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign in_pat  = !v_reg[13];
    assign in_pal  = (v_reg[13:8] == vri_pkg::PAL_WINDOW);
    assign v_inc   = v_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
    assign fetched = in_pat ? item_reg.pattern_read_data : mem_rdata;

    assign acc_addr = (s_item.reg_select == vri_pkg::SEL_OAM_DATA)
                    ? (vri_pkg::OAM_BASE | vri_pkg::MEM_AW'(ptr_reg))
                    : vri_pkg::vram_to_mem(v_reg[13:0], mirroring);

    always_comb
    begin
        mem_req.re    = accept;
        mem_req.we    = commit && (item_reg.req_type == vri_pkg::REQ_WRITE)
                      && ((item_reg.reg_select == vri_pkg::SEL_OAM_DATA)
                          || ((item_reg.reg_select == vri_pkg::SEL_DATA) && !in_pat));
        mem_req.addr  = (state_reg == ST_IDLE) ? acc_addr : maddr_reg;
        mem_req.wdata = item_reg.write_data;
    end

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        t_next      = t_reg;
        v_next      = v_reg;
        fine_x_next = fine_x_reg;
        toggle_next = toggle_reg;
        rbuf_next   = rbuf_reg;
        ptr_next    = ptr_reg;
        res         = '0;

        if (commit)
        begin
            unique case (item_reg.req_type)
                vri_pkg::REQ_READ:
                begin
                    unique case (item_reg.reg_select)
                        vri_pkg::SEL_STATUS:
                        begin
                            res.read_data = status_reg;
                            status_next   = {1'b0, status_reg[6:0]};
                            toggle_next   = 1'b0;
                        end
                        vri_pkg::SEL_OAM_DATA:
                        begin
                            res.read_data = mem_rdata;
                        end
                        vri_pkg::SEL_DATA:
                        begin
                            // palette reads bypass the buffer
                            res.read_data    = in_pal ? fetched : rbuf_reg;
                            rbuf_next        = fetched;
                            res.pattern_read = in_pat;
                            res.pattern_address = in_pat ? v_reg[12:0] : 13'd0;
                            v_next           = v_inc;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                vri_pkg::REQ_WRITE:
                begin
                    unique case (item_reg.reg_select)
                        vri_pkg::SEL_CTRL:
                        begin
                            ctrl_next      = item_reg.write_data;
                            t_next[11:10]  = item_reg.write_data[1:0];
                        end
                        vri_pkg::SEL_MASK:
                        begin
                            mask_next = item_reg.write_data;
                        end
                        vri_pkg::SEL_OAM_ADDR:
                        begin
                            ptr_next = item_reg.write_data;
                        end
                        vri_pkg::SEL_OAM_DATA:
                        begin
                            ptr_next = ptr_reg + 8'd1;
                        end
                        vri_pkg::SEL_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                fine_x_next = item_reg.write_data[2:0];
                                t_next[4:0] = item_reg.write_data[7:3];
                            end
                            else
                            begin
                                t_next[14:12] = item_reg.write_data[2:0];
                                t_next[9:5]   = item_reg.write_data[7:3];
                            end
                            toggle_next = !toggle_reg;
                        end
                        vri_pkg::SEL_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                t_next = {1'b0, item_reg.write_data[5:0], t_reg[7:0]};
                            end
                            else
                            begin
                                t_next = {t_reg[14:8], item_reg.write_data};
                                v_next = {t_reg[14:8], item_reg.write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        vri_pkg::SEL_DATA:
                        begin
                            if (in_pat)
                            begin
                                res.pattern_write      = 1'b1;
                                res.pattern_address    = v_reg[12:0];
                                res.pattern_write_data = item_reg.write_data;
                            end
                            v_next = v_inc;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                vri_pkg::REQ_VBLANK:
                begin
                    status_next[7]  = 1'b1;
                    res.nmi_request = ctrl_reg[7];
                end
                vri_pkg::REQ_PRE_CLEAR:
                begin
                    status_next = {3'b000, status_reg[4:0]};
                end
                default:
                begin
                end
            endcase
        end
        res.current_vram_address = v_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        maddr_next   = maddr_reg;
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        if (m_valid_reg && m_ready)
        begin
            m_valid_next = 1'b0;
        end
        if (accept)
        begin
            state_next = ST_EXEC;
            item_next  = s_item;
            maddr_next = acc_addr;
        end
        if (commit)
        begin
            state_next   = ST_IDLE;
            m_valid_next = 1'b1;
            result_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            item_reg    <= '0;
            maddr_reg   <= '0;
            m_valid_reg <= 1'b0;
            result_reg  <= '0;
            ctrl_reg    <= '0;
            mask_reg    <= '0;
            status_reg  <= '0;
            t_reg       <= '0;
            v_reg       <= '0;
            fine_x_reg  <= '0;
            toggle_reg  <= 1'b0;
            rbuf_reg    <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            item_reg    <= item_next;
            maddr_reg   <= maddr_next;
            m_valid_reg <= m_valid_next;
            result_reg  <= result_next;
            ctrl_reg    <= ctrl_next;
            mask_reg    <= mask_next;
            status_reg  <= status_next;
            t_reg       <= t_next;
            v_reg       <= v_next;
            fine_x_reg  <= fine_x_next;
            toggle_reg  <= toggle_next;
            rbuf_reg    <= rbuf_next;
            ptr_reg     <= ptr_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

`ifndef ASSERT_OFF
    a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter execution");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_valid_reg)
        else $error("finished item produced no result");

    a_write_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == ST_EXEC))
        else $error("storage write outside an item");

    a_regs_move_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> ($stable(fine_x_reg) && $stable(mask_reg) && $stable(v_reg)))
        else $error("register changed without a finished item");
`endif

endmodule

/* rtl/video_unit_register_interface_unit.sv */
// Top level of the video register interface: stream ports, APB config port,
// storage and register file. Depends on vri_pkg, vri_mem, vri_regs.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one CPU register access or video event per transfer.
//     s_tuser carries the request kind and register index, s_tdata the CPU
//     write byte and the pattern byte returned for the current bus address.
//   Output stream (m_*): exactly one result per accepted input transfer, in
//     order: read byte, NMI flag, external pattern access and the video
//     address after the access.
//   APB port: the name-table mirroring mode at address 0; write it only while idle.
// Item sequence
//   Storage is read in the accept cycle; the item commits and writes storage back
//   once the output register is free, and m_tvalid is registered from the commit.
//   s_tready stays low until the item commits, so items do not overlap.
// Reset
//   After rst_n releases, a fill sweep writes the storage one entry a cycle
//   (zero name tables and sprite memory, palette entry i = i).
//   s_tready stays low for the sweep; APB writes are taken throughout.
// Stall
//   A finished result waits in the output register while m_tready is low.
//   The next item is still accepted and read; it completes once the output
//   register drains.

module video_unit_register_interface_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [15:8] pattern_read_data
    input  logic [4:0]  s_tuser,   // [1:0] req_type, [4:2] reg_select

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] nmi_request, [9] pattern_read, [10] pattern_write,
    // [23:11] pattern_address, [31:24] pattern_write_data,
    // [46:32] current_vram_address, [47] zero
    output logic [47:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    vri_pkg::mirror_t   mirror_reg, mirror_next;
    vri_pkg::item_t     s_item;
    vri_pkg::result_t   m_result;
    vri_pkg::mem_req_t  mem_req;
    logic [7:0]         mem_rdata;
    logic               mem_busy;
    logic               cfg_write;

    // ---- configuration port ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == 2'd0);

    always_comb
    begin
        mirror_next = mirror_reg;
        if (cfg_write)
        begin
            mirror_next = vri_pkg::mirror_t'(pwdata[1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= vri_pkg::MIR_VERTICAL;
        end
        else
        begin
            mirror_reg <= mirror_next;
        end
    end

    assign prdata = (paddr == 2'd0) ? {30'd0, mirror_reg} : 32'd0;

    // ---- stream unpack / pack ----
    assign s_item.req_type          = vri_pkg::req_type_t'(s_tuser[1:0]);
    assign s_item.reg_select        = vri_pkg::reg_sel_t'(s_tuser[4:2]);
    assign s_item.write_data        = s_tdata[7:0];
    assign s_item.pattern_read_data = s_tdata[15:8];

    assign m_tdata = {1'b0,
                      m_result.current_vram_address,
                      m_result.pattern_write_data,
                      m_result.pattern_address,
                      m_result.pattern_write,
                      m_result.pattern_read,
                      m_result.nmi_request,
                      m_result.read_data};

    // ---- storage ----
    vri_mem u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    // ---- register file and sequencer ----
    vri_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mirroring (mirror_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_item    (s_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .mem_busy  (mem_busy)
    );

endmodule
